>>> sv/kpf_pkg.sv
// Shared types, constants and the key code table of the keypad pulse-frame encoder.
package kpf_pkg;

  localparam int unsigned NumKeys   = 13;
  localparam int unsigned HoldW     = 10;
  localparam int unsigned CodeW     = 8;
  localparam int unsigned BitPosW   = 4;
  localparam int unsigned PhaseW    = 2;

  localparam logic [HoldW-1:0]   HoldReset    = 10'd500;
  localparam logic [CodeW-1:0]   PendingReset = 8'd128;
  localparam logic [BitPosW-1:0] LastBitPos   = 4'd8;

  // Emitter phase, one-hot inside the block.
  typedef enum logic [3:0] {
    PH_START = 4'b0001,
    PH_WAIT  = 4'b0010,
    PH_SEND  = 4'b0100,
    PH_OFF   = 4'b1000
  } phase_e;

  // Phase numbers as seen on the result port.
  localparam logic [PhaseW-1:0] PhaseNumStart = 2'd0;
  localparam logic [PhaseW-1:0] PhaseNumWait  = 2'd1;
  localparam logic [PhaseW-1:0] PhaseNumSend  = 2'd2;
  localparam logic [PhaseW-1:0] PhaseNumOff   = 2'd3;

  typedef struct packed {
    phase_e               phase;
    logic [BitPosW-1:0]   bit_pos;
    logic [CodeW-1:0]     pending;
    logic [NumKeys-1:0]   last_levels;
    logic [HoldW-1:0]     led_cnt;
    logic                 led;
    logic                 envelope;
  } kpf_state_t;

  // Fixed code of each key, key 1 at index 0.
  function automatic logic [CodeW-1:0] key_code(input logic [3:0] idx);
    logic [CodeW-1:0] code;
    begin
      case (idx)
        4'd0:    code = 8'h55;
        4'd1:    code = 8'h56;
        4'd2:    code = 8'h59;
        4'd3:    code = 8'h5A;
        4'd4:    code = 8'h65;
        4'd5:    code = 8'h66;
        4'd6:    code = 8'h69;
        4'd7:    code = 8'h6A;
        4'd8:    code = 8'h95;
        4'd9:    code = 8'h96;
        4'd10:   code = 8'h99;
        4'd11:   code = 8'h9A;
        4'd12:   code = 8'hA5;
        default: code = 8'h00;
      endcase
      return code;
    end
  endfunction

  function automatic logic [PhaseW-1:0] phase_num(input phase_e ph);
    logic [PhaseW-1:0] num;
    begin
      unique case (ph)
        PH_START: num = PhaseNumStart;
        PH_WAIT:  num = PhaseNumWait;
        PH_SEND:  num = PhaseNumSend;
        PH_OFF:   num = PhaseNumOff;
        default:  num = PhaseNumStart;
      endcase
      return num;
    end
  endfunction

endpackage

>>> sv/kpf_next.sv
// Next-state logic for one tick: emitter, LED countdown and key edge detection.
module kpf_next
  import kpf_pkg::*;
(
  input  kpf_state_t         cur_i,
  input  logic [NumKeys-1:0] levels_i,
  input  logic [HoldW-1:0]   hold_i,
  output kpf_state_t         nxt_o
);

  kpf_state_t         emit;
  logic [BitPosW-1:0] pos_inc;
  logic [NumKeys-1:0] rising;
  logic               hit;
  logic [3:0]         hit_idx;

  assign pos_inc = cur_i.bit_pos + 4'd1;

  // Emitter step.
  always_comb begin
    emit = cur_i;
    unique case (cur_i.phase)
      PH_START: begin
        emit.phase = PH_WAIT;
      end
      PH_WAIT: begin
        if (cur_i.pending != '0) begin
          emit.envelope = 1'b1;
          emit.phase    = PH_SEND;
          emit.bit_pos  = '0;
        end
      end
      PH_SEND: begin
        emit.envelope = cur_i.pending[cur_i.bit_pos[2:0]];
        emit.bit_pos  = pos_inc;
        if (pos_inc == LastBitPos) begin
          emit.phase   = PH_OFF;
          emit.pending = '0;
        end
      end
      PH_OFF: begin
        emit.envelope = 1'b0;
        emit.phase    = PH_WAIT;
      end
      default: begin
        emit.envelope = 1'b0;
        emit.phase    = PH_WAIT;
      end
    endcase
  end

  // Highest-numbered new press wins.
  assign rising = levels_i & ~cur_i.last_levels;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = 0; k < NumKeys; k++) begin
      if (rising[k]) begin
        hit     = 1'b1;
        hit_idx = 4'(k);
      end
    end
  end

  always_comb begin
    nxt_o = emit;
    if (emit.led_cnt != '0) begin
      nxt_o.led_cnt = emit.led_cnt - 10'd1;
      if (emit.led_cnt == 10'd1) begin
        nxt_o.led = 1'b0;
      end
    end
    // Edge memory only advances while nothing is pending.
    if (emit.pending == '0) begin
      nxt_o.last_levels = levels_i;
      if (hit) begin
        nxt_o.pending = key_code(hit_idx);
        nxt_o.led     = 1'b1;
        nxt_o.led_cnt = (hold_i == '0) ? 10'd1 : hold_i;
      end
    end
  end

endmodule

>>> sv/keypad_to_pulse_frame_encoder.sv
// Top level of the keypad pulse-frame encoder: state register, handshakes, config.
//
// Each input item is one millisecond tick that carries the levels of 13 keys.
// Every accepted item produces exactly one result item: the carrier envelope,
// the activity LED, the pending code and the emitter phase, all as they stand
// after that tick has been processed.
//
// The result of an item accepted at one clock edge is presented on the output
// channel right after that edge. Throughput is one item per cycle. The state
// register doubles as the result register, and in_ready_o stays high while a
// result waits as long as the receiver takes it in the same cycle, so ticks
// can stream back to back.
//
// When the receiver stalls, the pending result holds and no new item is
// taken; the tick state only advances on accepted items.
//
// Reset puts the emitter in its start-up phase with code 128 pending, clears the
// edge memory, the LED and its countdown, and loads a hold of 500 ticks. The hold
// register must be written (cfg_we_i/cfg_wdata_i) only while idle; not enforced.
module keypad_to_pulse_frame_encoder
  import kpf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [HoldW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [NumKeys-1:0] key_levels_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               carrier_on_o,
  output logic               activity_led_o,
  output logic [CodeW-1:0]   pending_value_o,
  output logic [PhaseW-1:0]  emit_phase_o
);

  kpf_state_t       state_q, state_d;
  logic [HoldW-1:0] hold_q;
  logic             out_valid_q;
  logic             in_fire;

  // A new tick may enter whenever the result slot is free or being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  kpf_next u_next (
    .cur_i    (state_q),
    .levels_i (key_levels_i),
    .hold_i   (hold_q),
    .nxt_o    (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= PH_START;
      state_q.bit_pos     <= '0;
      state_q.pending     <= PendingReset;
      state_q.last_levels <= '0;
      state_q.led_cnt     <= '0;
      state_q.led         <= 1'b0;
      state_q.envelope    <= 1'b0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HoldReset;
    end else if (cfg_we_i) begin
      hold_q <= cfg_wdata_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign carrier_on_o    = state_q.envelope;
  assign activity_led_o  = state_q.led;
  assign pending_value_o = state_q.pending;
  assign emit_phase_o    = phase_num(state_q.phase);

  // An accepted tick always leaves a result behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted tick produced no result");

  // The carrier is only on while a frame is being sent; the last code bit
  // stays on the envelope through the tick that enters the final off phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.envelope |-> (state_q.phase == PH_SEND || state_q.phase == PH_OFF))
    else $error("carrier on outside the sending phase");

  // The LED is lit exactly while its countdown runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.led == (state_q.led_cnt != '0))
    else $error("LED and countdown disagree");

  // The bit counter never runs past the end of a code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bit_pos <= LastBitPos)
    else $error("bit position out of range");

endmodule
